// ===== design/installer_container_walker_core_assert.svh =====
// Assertion macros used by the walker core RTL.
`ifndef INSTALLER_CONTAINER_WALKER_CORE_ASSERT_SVH
`define INSTALLER_CONTAINER_WALKER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and idle during reset.
`define ICW_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("walker assertion failed");

// Next-cycle implication.
`define ICW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("walker assertion failed");

`endif

// ===== design/icw_pkg.sv =====
package icw_pkg;

    localparam int MAX_MEMBERS_DEF = 1024;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [15:0] STAMP = 16'h1a07;

    localparam logic [3:0] EV_MEMBER    = 4'd0;
    localparam logic [3:0] EV_VALID     = 4'd1;
    localparam logic [3:0] EV_BAD_SIG   = 4'd2;
    localparam logic [3:0] EV_BAD_END   = 4'd3;
    localparam logic [3:0] EV_RESERVED  = 4'd4;
    localparam logic [3:0] EV_METHOD    = 4'd5;
    localparam logic [3:0] EV_NEG_SIZE  = 4'd6;
    localparam logic [3:0] EV_OVERRUN   = 4'd7;
    localparam logic [3:0] EV_SIZE_DIFF = 4'd8;
    localparam logic [3:0] EV_NO_NAME   = 4'd9;
    localparam logic [3:0] EV_TOO_MANY  = 4'd10;
    localparam logic [3:0] EV_TRUNC     = 4'd11;

    typedef struct packed {
        logic [32:0] offset;
        logic [63:0] name_low;
        logic [31:0] name_high;
        logic [3:0]  name_length;
        logic [1:0]  method;
        logic [31:0] crc_value;
        logic [31:0] dos_timestamp;
        logic [15:0] attribute_word;
        logic [30:0] expanded_size;
        logic [30:0] stored_size;
    } member_t;

    typedef struct packed {
        logic        has_member;
        logic        has_verdict;
        logic [3:0]  verdict_code;
        logic [32:0] verdict_offset;
        member_t     member;
    } q_entry_t;

    typedef struct packed {
        logic [3:0] event_res;
        logic       last_of_run;
        member_t    member;
    } out_beat_t;

    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] r;
        begin
            case (idx)
                3'd0:    r = 8'h53;
                3'd1:    r = 8'h4d;
                3'd2:    r = 8'h53;
                3'd3:    r = 8'h49;
                3'd4:    r = 8'h50;
                3'd5:    r = 8'h41;
                3'd6:    r = 8'h4b;
                default: r = 8'h20;
            endcase
            return r;
        end
    endfunction

    // Control characters and characters that are illegal in file names map to '_'.
    function automatic logic [7:0] clean_char(input logic [7:0] c);
        logic [7:0] r;
        begin
            r = c;
            if (c < 8'h20 || c == 8'h2f || c == 8'h5c || c == 8'h22 || c == 8'h2a ||
                c == 8'h3a || c == 8'h3c || c == 8'h3e || c == 8'h3f || c == 8'h7c)
            begin
                r = 8'h5f;
            end
            return r;
        end
    endfunction

endpackage

// ===== design/icw_front.sv =====
module icw_front #(
    parameter int MAX_MEMBERS = icw_pkg::MAX_MEMBERS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [7:0]        byte_value,
    input  logic              last_byte,
    input  logic [31:0]       base_offset,
    input  logic              q_full,
    output logic              q_push,
    output icw_pkg::q_entry_t q_data
);

    localparam int AW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;

    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_RECORD  = 3'd1;
    localparam logic [2:0] PH_PAYLOAD = 3'd2;
    localparam logic [2:0] PH_INDEX   = 3'd3;
    localparam logic [2:0] PH_DONE    = 3'd4;

    logic [2:0]  phase_reg, phase_next;
    logic [5:0]  fpos_reg, fpos_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] room_reg, room_next;
    logic [31:0] mae_reg, mae_next;
    logic [30:0] pay_reg, pay_next;
    logic [16:0] count_reg, count_next;
    logic [18:0] rel_reg, rel_next;
    logic        iv_reg, iv_next;
    logic        sig_ok_reg, sig_ok_next;
    logic [7:0]  lo_byte_reg, lo_byte_next;
    logic [95:0] name_reg, name_next;
    logic        nstop_reg, nstop_next;
    logic [3:0]  nlen_reg, nlen_next;
    logic [31:0] ts_reg, ts_next;
    logic [31:0] crc_reg, crc_next;
    logic [15:0] attr_reg, attr_next;
    logic [7:0]  meth_reg, meth_next;
    logic [31:0] plain_reg, plain_next;
    logic [31:0] stored_reg, stored_next;
    logic [31:0] rs_reg, rs_next;

    logic [31:0] offs_mem [MAX_MEMBERS];
    logic [31:0] rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          mem_we;

    logic        accept;
    logic [18:0] rel_sel;
    logic [18:0] ent;

    assign accept = in_valid && !q_full;

    // The offset table is read one index byte ahead of the byte that uses it.
    always_comb
    begin
        rel_sel = (phase_reg == PH_INDEX && accept) ? rel_reg + 19'd1 : rel_reg;
        ent     = (rel_sel >= 19'd6) ? ((rel_sel - 19'd6) >> 2) : 19'd0;
        rd_addr = ent[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            offs_mem[count_reg[AW-1:0]] <= rs_reg;
        end
        if (mem_we && count_reg[AW-1:0] == rd_addr)
        begin
            rd_data_reg <= rs_reg;
        end
        else
        begin
            rd_data_reg <= offs_mem[rd_addr];
        end
    end

    always_comb
    begin
        logic [3:0]  err;
        logic        fin;
        logic [32:0] fin_size;
        logic        sr_req;
        logic [31:0] sr_room;
        logic [31:0] room_dec;
        logic [31:0] pos_inc;
        logic [31:0] full_mae;
        logic [7:0]  c;
        logic [7:0]  want;
        logic [18:0] isize;
        logic [18:0] relm;
        logic [95:0] masked;

        phase_next   = phase_reg;
        fpos_next    = fpos_reg;
        pos_next     = pos_reg;
        room_next    = room_reg;
        mae_next     = mae_reg;
        pay_next     = pay_reg;
        count_next   = count_reg;
        rel_next     = rel_reg;
        iv_next      = iv_reg;
        sig_ok_next  = sig_ok_reg;
        lo_byte_next = lo_byte_reg;
        name_next    = name_reg;
        nstop_next   = nstop_reg;
        nlen_next    = nlen_reg;
        ts_next      = ts_reg;
        crc_next     = crc_reg;
        attr_next    = attr_reg;
        meth_next    = meth_reg;
        plain_next   = plain_reg;
        stored_next  = stored_reg;
        rs_next      = rs_reg;
        mem_we       = 1'b0;
        q_data       = '0;
        err          = icw_pkg::EV_MEMBER;
        fin          = 1'b0;
        fin_size     = '0;
        sr_req       = 1'b0;
        sr_room      = '0;
        room_dec     = room_reg - 32'd1;
        pos_inc      = pos_reg + 32'd1;
        full_mae     = {byte_value, mae_reg[23:0]};
        c            = icw_pkg::clean_char(byte_value);
        want         = '0;
        isize        = 19'd6 + {count_reg, 2'b00};
        relm         = rel_reg - 19'd6;
        masked       = '0;
        for (int j = 0; j < 12; j++)
        begin
            if (4'(j) < nlen_reg)
            begin
                masked[8*j +: 8] = name_reg[8*j +: 8];
            end
        end

        if (accept)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    fpos_next = fpos_reg + 6'd1;
                    pos_next  = pos_inc;
                    if (fpos_reg < 6'd8)
                    begin
                        sig_ok_next = sig_ok_reg &&
                                      (byte_value == icw_pkg::sig_byte(fpos_reg[2:0]));
                    end
                    if (fpos_reg == 6'd8)
                    begin
                        lo_byte_next = byte_value;
                    end
                    if (fpos_reg == 6'd9)
                    begin
                        sig_ok_next = sig_ok_reg && ({byte_value, lo_byte_reg} == icw_pkg::STAMP);
                    end
                    if (fpos_reg inside {[6'd10:6'd12]})
                    begin
                        mae_next[{fpos_reg[1:0] + 2'd2, 3'b000} +: 8] = byte_value;
                    end
                    if (fpos_reg == 6'd13)
                    begin
                        mae_next = full_mae;
                        if (!sig_ok_reg)
                        begin
                            err = icw_pkg::EV_BAD_SIG;
                        end
                        else if (full_mae <= 32'd14)
                        begin
                            err = icw_pkg::EV_BAD_END;
                        end
                        else
                        begin
                            sr_req  = 1'b1;
                            sr_room = full_mae - 32'd14;
                        end
                    end
                end
                PH_RECORD:
                begin
                    fpos_next = fpos_reg + 6'd1;
                    pos_next  = pos_inc;
                    room_next = room_dec;
                    if (fpos_reg < 6'd12 && !nstop_reg)
                    begin
                        if (byte_value == 8'd0)
                        begin
                            nstop_next = 1'b1;
                        end
                        else
                        begin
                            name_next[{fpos_reg[3:0], 3'b000} +: 8] = c;
                            // Trailing spaces and dots do not extend the name.
                            if (c != 8'h20 && c != 8'h2e)
                            begin
                                nlen_next = fpos_reg[3:0] + 4'd1;
                            end
                        end
                    end
                    if (fpos_reg inside {[6'd13:6'd14]})
                    begin
                        ts_next[{1'b1, !fpos_reg[0], 3'b000} +: 8] = byte_value;
                    end
                    if (fpos_reg inside {[6'd15:6'd16]})
                    begin
                        ts_next[{1'b0, !fpos_reg[0], 3'b000} +: 8] = byte_value;
                    end
                    if (fpos_reg inside {[6'd17:6'd20]})
                    begin
                        crc_next[{fpos_reg[1:0] + 2'd3, 3'b000} +: 8] = byte_value;
                    end
                    if (fpos_reg inside {[6'd21:6'd22]})
                    begin
                        attr_next[{!fpos_reg[0], 3'b000} +: 8] = byte_value;
                    end
                    if (fpos_reg == 6'd23)
                    begin
                        meth_next = byte_value;
                    end
                    if (fpos_reg inside {[6'd24:6'd27]})
                    begin
                        plain_next[{fpos_reg[1:0], 3'b000} +: 8] = byte_value;
                    end
                    if (fpos_reg inside {[6'd28:6'd31]})
                    begin
                        stored_next[{fpos_reg[1:0], 3'b000} +: 8] = byte_value;
                    end
                    if (fpos_reg == 6'd32)
                    begin
                        lo_byte_next = byte_value;
                    end
                    if (fpos_reg == 6'd33)
                    begin
                        if ({byte_value, lo_byte_reg} != 16'd0)
                        begin
                            err = icw_pkg::EV_RESERVED;
                        end
                        else if (meth_reg != 8'd1 && meth_reg != 8'd2)
                        begin
                            err = icw_pkg::EV_METHOD;
                        end
                        else if (plain_reg[31] || stored_reg[31])
                        begin
                            err = icw_pkg::EV_NEG_SIZE;
                        end
                        else if (room_dec < stored_reg)
                        begin
                            err = icw_pkg::EV_OVERRUN;
                        end
                        else if (meth_reg == 8'd2 && stored_reg != plain_reg)
                        begin
                            err = icw_pkg::EV_SIZE_DIFF;
                        end
                        else if (nlen_reg == 4'd0)
                        begin
                            err = icw_pkg::EV_NO_NAME;
                        end
                        else if (count_reg >= 17'(MAX_MEMBERS))
                        begin
                            err = icw_pkg::EV_TOO_MANY;
                        end
                        else
                        begin
                            q_data.has_member            = 1'b1;
                            q_data.member.offset         = {1'b0, base_offset} + {1'b0, rs_reg};
                            q_data.member.name_low       = masked[63:0];
                            q_data.member.name_high      = masked[95:64];
                            q_data.member.name_length    = nlen_reg;
                            q_data.member.method         = meth_reg[1:0];
                            q_data.member.crc_value      = crc_reg;
                            q_data.member.dos_timestamp  = ts_reg;
                            q_data.member.attribute_word = attr_reg;
                            q_data.member.expanded_size  = plain_reg[30:0];
                            q_data.member.stored_size    = stored_reg[30:0];
                            mem_we     = 1'b1;
                            count_next = count_reg + 17'd1;
                            if (stored_reg == 32'd0)
                            begin
                                sr_req  = 1'b1;
                                sr_room = room_dec;
                            end
                            else
                            begin
                                phase_next = PH_PAYLOAD;
                                pay_next   = stored_reg[30:0];
                            end
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    pos_next  = pos_inc;
                    room_next = room_dec;
                    pay_next  = pay_reg - 31'd1;
                    if (pay_reg == 31'd1)
                    begin
                        sr_req  = 1'b1;
                        sr_room = room_dec;
                    end
                end
                PH_INDEX:
                begin
                    if (rel_reg < 19'd4)
                    begin
                        want = 8'd0;
                    end
                    else if (rel_reg == 19'd4)
                    begin
                        want = count_reg[7:0];
                    end
                    else if (rel_reg == 19'd5)
                    begin
                        want = count_reg[15:8];
                    end
                    else
                    begin
                        want = rd_data_reg[{relm[1:0], 3'b000} +: 8];
                    end
                    if (byte_value != want)
                    begin
                        iv_next = 1'b0;
                    end
                    rel_next = rel_reg + 19'd1;
                    if (rel_reg + 19'd1 >= isize)
                    begin
                        fin      = 1'b1;
                        fin_size = iv_next ? {1'b0, mae_reg} + 33'(isize) : {1'b0, mae_reg};
                    end
                end
                default:
                begin
                end
            endcase

            // Record boundary: pick the next record, the index, or an overrun.
            if (sr_req)
            begin
                room_next = sr_room;
                if (sr_room == 32'd0)
                begin
                    phase_next = PH_INDEX;
                end
                else if (sr_room < 32'd34)
                begin
                    err = icw_pkg::EV_OVERRUN;
                end
                else
                begin
                    phase_next = PH_RECORD;
                    fpos_next  = '0;
                    rs_next    = pos_next;
                    nstop_next = 1'b0;
                    nlen_next  = '0;
                end
            end

            if (phase_reg != PH_DONE)
            begin
                if (err != icw_pkg::EV_MEMBER)
                begin
                    q_data.has_verdict  = 1'b1;
                    q_data.verdict_code = err;
                    phase_next          = PH_DONE;
                end
                else if (fin || last_byte)
                begin
                    q_data.has_verdict = 1'b1;
                    if (fin)
                    begin
                        q_data.verdict_code   = icw_pkg::EV_VALID;
                        q_data.verdict_offset = fin_size;
                    end
                    else if (phase_next == PH_HEADER)
                    begin
                        q_data.verdict_code = icw_pkg::EV_TRUNC;
                    end
                    else if (phase_next == PH_INDEX)
                    begin
                        q_data.verdict_code   = icw_pkg::EV_VALID;
                        q_data.verdict_offset = {1'b0, mae_reg};
                    end
                    else
                    begin
                        q_data.verdict_code = icw_pkg::EV_BAD_END;
                    end
                    phase_next = PH_DONE;
                end
            end
        end

        q_push = accept && (q_data.has_member || q_data.has_verdict);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            fpos_reg    <= '0;
            pos_reg     <= '0;
            room_reg    <= '0;
            mae_reg     <= '0;
            pay_reg     <= '0;
            count_reg   <= '0;
            rel_reg     <= '0;
            iv_reg      <= 1'b1;
            sig_ok_reg  <= 1'b1;
            lo_byte_reg <= '0;
            name_reg    <= '0;
            nstop_reg   <= 1'b0;
            nlen_reg    <= '0;
            ts_reg      <= '0;
            crc_reg     <= '0;
            attr_reg    <= '0;
            meth_reg    <= '0;
            plain_reg   <= '0;
            stored_reg  <= '0;
            rs_reg      <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            fpos_reg    <= fpos_next;
            pos_reg     <= pos_next;
            room_reg    <= room_next;
            mae_reg     <= mae_next;
            pay_reg     <= pay_next;
            count_reg   <= count_next;
            rel_reg     <= rel_next;
            iv_reg      <= iv_next;
            sig_ok_reg  <= sig_ok_next;
            lo_byte_reg <= lo_byte_next;
            name_reg    <= name_next;
            nstop_reg   <= nstop_next;
            nlen_reg    <= nlen_next;
            ts_reg      <= ts_next;
            crc_reg     <= crc_next;
            attr_reg    <= attr_next;
            meth_reg    <= meth_next;
            plain_reg   <= plain_next;
            stored_reg  <= stored_next;
            rs_reg      <= rs_next;
        end
    end

endmodule

// ===== design/icw_queue.sv =====
module icw_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  icw_pkg::q_entry_t push_data,
    input  logic              pop,
    output logic              full,
    output logic              empty,
    output icw_pkg::q_entry_t head
);

    localparam int DEPTH = icw_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);

    icw_pkg::q_entry_t entries [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   cnt_reg, cnt_next;

    assign full  = (cnt_reg == (PW+1)'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + (push ? PW'(1) : PW'(0));
        rd_ptr_next = rd_ptr_reg + (pop ? PW'(1) : PW'(0));
        cnt_next    = cnt_reg + (push ? (PW+1)'(1) : (PW+1)'(0))
                              - (pop ? (PW+1)'(1) : (PW+1)'(0));
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== design/icw_back.sv =====
module icw_back (
    input  logic               clk,
    input  logic               rst_n,
    input  icw_pkg::q_entry_t  head,
    input  logic               empty,
    input  logic               out_stall,
    output logic               pop,
    output logic               out_valid,
    output icw_pkg::out_beat_t beat
);

    logic               valid_reg, valid_next;
    logic               half_reg, half_next;
    icw_pkg::out_beat_t beat_reg, beat_next;

    assign out_valid = valid_reg;
    assign beat      = beat_reg;

    // A queue entry with a member and a verdict goes out as two beats.
    always_comb
    begin
        valid_next = valid_reg;
        half_next  = half_reg;
        beat_next  = beat_reg;
        pop        = 1'b0;
        if (!valid_reg || !out_stall)
        begin
            if (!empty)
            begin
                valid_next = 1'b1;
                if (head.has_member && !half_reg)
                begin
                    beat_next.event_res   = icw_pkg::EV_MEMBER;
                    beat_next.last_of_run = !head.has_verdict;
                    beat_next.member      = head.member;
                    if (head.has_verdict)
                    begin
                        half_next = 1'b1;
                    end
                    else
                    begin
                        pop = 1'b1;
                    end
                end
                else
                begin
                    beat_next.event_res     = head.verdict_code;
                    beat_next.last_of_run   = 1'b1;
                    beat_next.member        = '0;
                    beat_next.member.offset = head.verdict_offset;
                    pop       = 1'b1;
                    half_next = 1'b0;
                end
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            half_reg  <= 1'b0;
            beat_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            half_reg  <= half_next;
            beat_reg  <= beat_next;
        end
    end

endmodule

// ===== design/installer_container_walker_core.sv =====
// Channel   Direction  Handshake            Beat contents
// input     in         in_valid / in_stall  byte_value, last_byte
// result    out        out_valid/out_stall  event_res, last_of_run, offset, name, record fields
// config    in         cfg_write            cfg_data (base offset)
//
// One byte is taken per cycle while in_stall is low; a byte that yields a member
// and a verdict takes two output beats. The first result of a byte passes through
// the result queue and the output register before out_valid rises.
// in_stall rises only when the four-entry result queue is full.
// Reset clears the walk state; the record offset table needs no clearing.
module installer_container_walker_core #(
    parameter int MAX_MEMBERS = icw_pkg::MAX_MEMBERS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  byte_value,
    input  logic        last_byte,
    input  logic        cfg_write,
    input  logic [31:0] cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  event_res,
    output logic        last_of_run,
    output logic [32:0] offset,
    output logic [63:0] name_low,
    output logic [31:0] name_high,
    output logic [3:0]  name_length,
    output logic [1:0]  method,
    output logic [31:0] crc_value,
    output logic [31:0] dos_timestamp,
    output logic [15:0] attribute_word,
    output logic [30:0] expanded_size,
    output logic [30:0] stored_size
);

`include "installer_container_walker_core_assert.svh"

    logic [31:0]        base_reg;
    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_empty;
    icw_pkg::q_entry_t  q_in;
    icw_pkg::q_entry_t  q_head;
    icw_pkg::out_beat_t beat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (cfg_write)
        begin
            base_reg <= cfg_data;
        end
    end

    assign in_stall = q_full;

    icw_front #(.MAX_MEMBERS(MAX_MEMBERS)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .byte_value   (byte_value),
        .last_byte    (last_byte),
        .base_offset  (base_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_in)
    );

    icw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    icw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .empty     (q_empty),
        .out_stall (out_stall),
        .pop       (q_pop),
        .out_valid (out_valid),
        .beat      (beat)
    );

    assign event_res      = beat.event_res;
    assign last_of_run    = beat.last_of_run;
    assign offset         = beat.member.offset;
    assign name_low       = beat.member.name_low;
    assign name_high      = beat.member.name_high;
    assign name_length    = beat.member.name_length;
    assign method         = beat.member.method;
    assign crc_value      = beat.member.crc_value;
    assign dos_timestamp  = beat.member.dos_timestamp;
    assign attribute_word = beat.member.attribute_word;
    assign expanded_size  = beat.member.expanded_size;
    assign stored_size    = beat.member.stored_size;

    `ICW_ASSERT_IMPL(a_no_overflow, q_full, !q_push)
    `ICW_ASSERT_IMPL(a_verdict_last, out_valid && event_res != icw_pkg::EV_MEMBER, last_of_run && name_length == 4'd0)
    `ICW_ASSERT_IMPL(a_member_method, out_valid && event_res == icw_pkg::EV_MEMBER, method == 2'd1 || method == 2'd2)
    `ICW_ASSERT_NEXT(a_pair_follows, out_valid && !out_stall && !last_of_run, out_valid)

endmodule

// ===== tb/sv/icw_checker.sv =====
`timescale 1ns / 1ps

module icw_checker #(
    parameter int MAX_MEMBERS = icw_pkg::MAX_MEMBERS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  byte_value,
    input  logic        last_byte,
    input  logic        cfg_write,
    input  logic [31:0] cfg_data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [3:0]  event_res,
    input  logic        last_of_run,
    input  logic [32:0] offset,
    input  logic [63:0] name_low,
    input  logic [31:0] name_high,
    input  logic [3:0]  name_length,
    input  logic [1:0]  method,
    input  logic [31:0] crc_value,
    input  logic [31:0] dos_timestamp,
    input  logic [15:0] attribute_word,
    input  logic [30:0] expanded_size,
    input  logic [30:0] stored_size,
    output int          fails,
    output int          pending
);

    typedef enum logic [2:0] {
        WALK_HEADER,
        WALK_RECORD,
        WALK_PAYLOAD,
        WALK_INDEX,
        WALK_DONE
    } walk_phase_e;

    typedef struct {
        logic [3:0]       ev;
        logic             last;
        icw_pkg::member_t m;
    } walk_result_t;

    localparam logic [63:0] MAGIC        = 64'h204b_4150_4953_4d53;
    localparam int          HEADER_BYTES = 14;
    localparam int          RECORD_BYTES = 34;
    localparam int          NAME_CHARS   = 12;

    walk_result_t walk_results_q[$];

    walk_phase_e walk_phase;
    int          field_pos;
    longint      stream_pos;
    longint      area_end;
    longint      payload_left;
    logic [7:0]  rec_bytes [0:RECORD_BYTES-1];
    int          members_seen;
    logic [31:0] member_offsets [0:MAX_MEMBERS-1];
    bit          index_ok;
    logic [31:0] base_addr;
    int          fail_total;

    function automatic longint le_field(input int at, input int n);
        longint v;
        int     i;
        v = 0;
        for (i = n - 1; i >= 0; i--)
            v = (v << 8) | rec_bytes[at + i];
        return v;
    endfunction

    // Code 0 (member) also stands for "no error" in the walk.
    function automatic logic [3:0] open_record();
        if (stream_pos >= area_end)
        begin
            walk_phase = WALK_INDEX;
            return icw_pkg::EV_MEMBER;
        end
        if (area_end - stream_pos < RECORD_BYTES)
            return icw_pkg::EV_OVERRUN;
        walk_phase = WALK_RECORD;
        field_pos  = 0;
        return icw_pkg::EV_MEMBER;
    endfunction

    function automatic logic [3:0] close_record(output icw_pkg::member_t m);
        logic [7:0] c;
        logic [7:0] chars [0:NAME_CHARS-1];
        int         len;
        int         i;
        longint     plain;
        longint     stored;
        longint     cursor;
        logic [7:0] meth;
        m      = '0;
        meth   = rec_bytes[23];
        plain  = le_field(24, 4);
        stored = le_field(28, 4);
        cursor = stream_pos - RECORD_BYTES;
        if (le_field(32, 2) != 0)
            return icw_pkg::EV_RESERVED;
        if (meth != 8'd1 && meth != 8'd2)
            return icw_pkg::EV_METHOD;
        if (plain[31] || stored[31])
            return icw_pkg::EV_NEG_SIZE;
        if (area_end - stream_pos < stored)
            return icw_pkg::EV_OVERRUN;
        if (meth == 8'd2 && stored != plain)
            return icw_pkg::EV_SIZE_DIFF;
        len = 0;
        for (i = 0; i < NAME_CHARS; i++)
        begin
            c = rec_bytes[i];
            if (c == 8'h00)
                break;
            if (c < 8'h20 || c inside {8'h2f, 8'h5c, 8'h22, 8'h2a, 8'h3a, 8'h3c, 8'h3e,
                                      8'h3f, 8'h7c})
                c = 8'h5f;
            chars[len] = c;
            len++;
        end
        while (len > 0 && (chars[len-1] == 8'h20 || chars[len-1] == 8'h2e))
            len--;
        if (len == 0)
            return icw_pkg::EV_NO_NAME;
        if (members_seen >= MAX_MEMBERS)
            return icw_pkg::EV_TOO_MANY;
        for (i = 0; i < len; i++)
        begin
            if (i < 8)
                m.name_low[8*i +: 8] = chars[i];
            else
                m.name_high[8*(i-8) +: 8] = chars[i];
        end
        member_offsets[members_seen] = cursor[31:0];
        members_seen++;
        m.offset         = {1'b0, base_addr} + 33'(cursor);
        m.name_length    = 4'(len);
        m.method         = meth[1:0];
        m.crc_value      = 32'(le_field(17, 4));
        m.dos_timestamp  = 32'((le_field(13, 2) << 16) | le_field(15, 2));
        m.attribute_word = 16'(le_field(21, 2));
        m.expanded_size  = 31'(plain);
        m.stored_size    = 31'(stored);
        payload_left     = stored;
        return icw_pkg::EV_MEMBER;
    endfunction

    task automatic take_byte(input logic [7:0] b, input logic is_last);
        walk_result_t r;
        logic [3:0]   err;
        bit           finished;
        longint       final_size;
        longint       rel;
        longint       isize;
        longint       slot;
        int           k;
        int           before_n;
        logic [7:0]   want;
        if (walk_phase == WALK_DONE)
            return;
        err      = icw_pkg::EV_MEMBER;
        finished = 0;
        final_size = 0;
        before_n = walk_results_q.size();
        case (walk_phase)
            WALK_HEADER:
            begin
                rec_bytes[field_pos] = b;
                field_pos++;
                stream_pos++;
                if (field_pos >= HEADER_BYTES)
                begin
                    if ({rec_bytes[7], rec_bytes[6], rec_bytes[5], rec_bytes[4], rec_bytes[3],
                         rec_bytes[2], rec_bytes[1], rec_bytes[0]} != MAGIC ||
                        le_field(8, 2) != icw_pkg::STAMP)
                        err = icw_pkg::EV_BAD_SIG;
                    else
                    begin
                        area_end = le_field(10, 4);
                        if (area_end <= HEADER_BYTES)
                            err = icw_pkg::EV_BAD_END;
                        else
                            err = open_record();
                    end
                end
            end
            WALK_RECORD:
            begin
                rec_bytes[field_pos] = b;
                field_pos++;
                stream_pos++;
                if (field_pos >= RECORD_BYTES)
                begin
                    err = close_record(r.m);
                    if (err == icw_pkg::EV_MEMBER)
                    begin
                        r.ev   = icw_pkg::EV_MEMBER;
                        r.last = 1'b0;
                        walk_results_q.push_back(r);
                        if (payload_left == 0)
                            err = open_record();
                        else
                            walk_phase = WALK_PAYLOAD;
                    end
                end
            end
            WALK_PAYLOAD:
            begin
                stream_pos++;
                payload_left--;
                if (payload_left == 0)
                    err = open_record();
            end
            default:
            begin
                rel   = stream_pos - area_end;
                isize = 6 + 4 * longint'(members_seen);
                if (rel < 4)
                begin
                    if (b != 8'h00)
                        index_ok = 0;
                end
                else if (rel < 6)
                begin
                    want = (rel == 4) ? 8'(members_seen) : 8'(members_seen >> 8);
                    if (b != want)
                        index_ok = 0;
                end
                else
                begin
                    slot = (rel - 6) >> 2;
                    k    = int'((rel - 6) & 3);
                    if (slot < members_seen && slot < MAX_MEMBERS)
                    begin
                        if (b != member_offsets[slot][8*k +: 8])
                            index_ok = 0;
                    end
                end
                stream_pos++;
                if (rel + 1 >= isize)
                begin
                    finished   = 1;
                    final_size = index_ok ? area_end + isize : area_end;
                end
            end
        endcase

        r.m    = '0;
        r.last = 1'b0;
        if (err != icw_pkg::EV_MEMBER)
        begin
            r.ev = err;
            walk_phase = WALK_DONE;
            walk_results_q.push_back(r);
        end
        else if (finished || is_last)
        begin
            if (finished)
            begin
                r.ev       = icw_pkg::EV_VALID;
                r.m.offset = 33'(final_size);
            end
            else if (walk_phase == WALK_HEADER)
                r.ev = icw_pkg::EV_TRUNC;
            else if (walk_phase == WALK_INDEX)
            begin
                r.ev       = icw_pkg::EV_VALID;
                r.m.offset = 33'(area_end);
            end
            else
                r.ev = icw_pkg::EV_BAD_END;
            walk_phase = WALK_DONE;
            walk_results_q.push_back(r);
        end
        if (walk_results_q.size() > before_n)
            walk_results_q[$].last = 1'b1;
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        fail_total++;
    endtask

    task automatic compare_beat();
        walk_result_t e;
        if (walk_results_q.size() == 0)
        begin
            report("unexpected beat, event_res", event_res, 0);
            return;
        end
        e = walk_results_q.pop_front();
        if (event_res != e.ev)                     report("event_res", event_res, e.ev);
        if (last_of_run != e.last)                 report("last_of_run", last_of_run, e.last);
        if (offset != e.m.offset)                  report("offset", offset, e.m.offset);
        if (name_low != e.m.name_low)              report("name_low", name_low, e.m.name_low);
        if (name_high != e.m.name_high)            report("name_high", name_high, e.m.name_high);
        if (name_length != e.m.name_length)
            report("name_length", name_length, e.m.name_length);
        if (method != e.m.method)                  report("method", method, e.m.method);
        if (crc_value != e.m.crc_value)            report("crc_value", crc_value, e.m.crc_value);
        if (dos_timestamp != e.m.dos_timestamp)
            report("dos_timestamp", dos_timestamp, e.m.dos_timestamp);
        if (attribute_word != e.m.attribute_word)
            report("attribute_word", attribute_word, e.m.attribute_word);
        if (expanded_size != e.m.expanded_size)
            report("expanded_size", expanded_size, e.m.expanded_size);
        if (stored_size != e.m.stored_size)
            report("stored_size", stored_size, e.m.stored_size);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_phase   = WALK_HEADER;
            field_pos    = 0;
            stream_pos   = 0;
            area_end     = 0;
            payload_left = 0;
            members_seen = 0;
            index_ok     = 1;
            base_addr    = '0;
            fail_total   = 0;
            walk_results_q.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
                compare_beat();
            if (cfg_write)
                base_addr = cfg_data;
            if (in_valid && !in_stall)
                take_byte(byte_value, last_byte);
        end
        fails   <= fail_total;
        pending <= walk_results_q.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    typedef logic [7:0] rec_t [0:33];

    localparam int WATCHDOG_LIMIT = 1000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  byte_value = '0;
    logic        last_byte = 1'b0;
    logic        cfg_write = 1'b0;
    logic [31:0] cfg_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  event_res;
    logic        last_of_run;
    logic [32:0] offset;
    logic [63:0] name_low;
    logic [31:0] name_high;
    logic [3:0]  name_length;
    logic [1:0]  method;
    logic [31:0] crc_value;
    logic [31:0] dos_timestamp;
    logic [15:0] attribute_word;
    logic [30:0] expanded_size;
    logic [30:0] stored_size;
    int          fails;
    int          pending;

    logic [7:0]  container_q[$];
    bit          end_mark_q[$];
    int          record_starts_q[$];
    int          cfg_pos_q[$];
    logic [31:0] cfg_val_q[$];
    int          idle_cycles = 0;
    int          stall_left = 0;
    int          result_beats = 0;

    always #2 clk = ~clk;

    installer_container_walker_core u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .byte_value(byte_value), .last_byte(last_byte),
        .cfg_write(cfg_write), .cfg_data(cfg_data),
        .out_valid(out_valid), .out_stall(out_stall),
        .event_res(event_res), .last_of_run(last_of_run), .offset(offset),
        .name_low(name_low), .name_high(name_high), .name_length(name_length),
        .method(method), .crc_value(crc_value), .dos_timestamp(dos_timestamp),
        .attribute_word(attribute_word), .expanded_size(expanded_size),
        .stored_size(stored_size)
    );

    icw_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .byte_value(byte_value), .last_byte(last_byte),
        .cfg_write(cfg_write), .cfg_data(cfg_data),
        .out_valid(out_valid), .out_stall(out_stall),
        .event_res(event_res), .last_of_run(last_of_run), .offset(offset),
        .name_low(name_low), .name_high(name_high), .name_length(name_length),
        .method(method), .crc_value(crc_value), .dos_timestamp(dos_timestamp),
        .attribute_word(attribute_word), .expanded_size(expanded_size),
        .stored_size(stored_size),
        .fails(fails), .pending(pending)
    );

    // Result-side stall: a fresh random hold after every accepted beat, with
    // some stretches where the receiver never stalls.
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            result_beats <= result_beats + 1;
            if ((result_beats / 8) % 3 == 2)
            begin
                stall_left <= 0;
                out_stall  <= 1'b0;
            end
            else
            begin
                stall_left <= $urandom_range(0, 9);
                out_stall  <= 1'b0;
            end
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat moved for %0d cycles", idle_cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // style 0 is random; 1 to 6 are the directed corner records. A flaw other
    // than the member code plants that record error.
    task automatic make_member(input int style, input logic [3:0] flaw,
                               output rec_t r, output int pay);
        int          i;
        logic [31:0] plain;
        logic [31:0] stored;
        logic [7:0]  meth;
        for (i = 0; i < 34; i++)
            r[i] = 8'($urandom);
        r[0]   = 8'($urandom_range(8'h41, 8'h5a));
        meth   = 8'($urandom_range(1, 2));
        stored = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 3);
        plain  = (meth == 8'd1) ? ($urandom & 32'h7fff_ffff) : stored;
        case (style)
            1:
            begin
                for (i = 0; i < 12; i++)
                    r[i] = 8'hff;
                for (i = 12; i < 23; i++)
                    r[i] = 8'hff;
                meth = 8'd1; plain = 32'h7fff_ffff; stored = 0;
            end
            2:
            begin
                for (i = 1; i < 23; i++)
                    r[i] = 8'h00;
                meth = 8'd2; plain = 0; stored = 0;
            end
            3:
            begin
                r[0] = 8'h78; r[1] = 8'h2f; r[2] = 8'h5c; r[3] = 8'h22; r[4] = 8'h2a;
                r[5] = 8'h3a; r[6] = 8'h3c; r[7] = 8'h3e; r[8] = 8'h3f; r[9] = 8'h7c;
                r[10] = 8'h1f; r[11] = 8'h2e;
            end
            4:
            begin
                r[0] = 8'h61; r[1] = 8'h62;
                for (i = 2; i < 12; i++)
                    r[i] = (i % 2 == 0) ? 8'h2e : 8'h20;
            end
            5:
            begin
                r[0] = 8'h71; r[1] = 8'h00;
            end
            6:
            begin
                meth = 8'd2; plain = 3; stored = 3;
            end
            default: ;
        endcase
        r[32] = 8'h00;
        r[33] = 8'h00;
        case (flaw)
            icw_pkg::EV_RESERVED:
            begin
                r[32] = 8'($urandom_range(0, 255));
                r[33] = (r[32] == 8'h00) ? 8'($urandom_range(1, 255)) : 8'($urandom);
            end
            icw_pkg::EV_METHOD:
                meth = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(3, 255));
            icw_pkg::EV_NEG_SIZE:
            begin
                if ($urandom_range(0, 1) == 0)
                    plain = plain | 32'h8000_0000;
                else
                    stored = stored | 32'h8000_0000;
            end
            icw_pkg::EV_OVERRUN:
            begin
                stored = $urandom_range(1, 32'h7fff_ffff);
                plain  = stored;
            end
            icw_pkg::EV_SIZE_DIFF:
            begin
                meth = 8'd2; stored = 1; plain = $urandom_range(2, 32'h7fff_ffff);
            end
            icw_pkg::EV_NO_NAME:
            begin
                for (i = 0; i < 12; i++)
                    r[i] = ($urandom_range(0, 1) == 0) ? 8'h20 : 8'h2e;
                if ($urandom_range(0, 2) == 0)
                    r[$urandom_range(0, 11)] = 8'h00;
            end
            default: ;
        endcase
        r[23] = meth;
        for (i = 0; i < 4; i++)
        begin
            r[24 + i] = plain[8*i +: 8];
            r[28 + i] = stored[8*i +: 8];
        end
        pay = (flaw == icw_pkg::EV_MEMBER || flaw == icw_pkg::EV_SIZE_DIFF) ? int'(stored) : 0;
    endtask

    task automatic add_member(input int style, input logic [3:0] flaw);
        rec_t r;
        int   pay;
        int   i;
        make_member(style, flaw, r, pay);
        record_starts_q.push_back(container_q.size());
        for (i = 0; i < 34; i++)
            container_q.push_back(r[i]);
        for (i = 0; i < pay; i++)
            container_q.push_back(8'($urandom));
    endtask

    task automatic build_container();
        int          ending;
        int          i;
        int          s;
        int          idx_start;
        logic [31:0] area_end;
        logic [3:0]  flaw;
        ending = $urandom_range(0, 7);
        for (i = 0; i < 14; i++)
            container_q.push_back(8'h00);
        for (s = 1; s <= 6; s++)
            add_member(s, icw_pkg::EV_MEMBER);
        while (container_q.size() < 1700)
            add_member(0, icw_pkg::EV_MEMBER);
        // An empty payload last lets a member and the verdict share a beat run when the end mark is on its final byte.
        add_member(2, icw_pkg::EV_MEMBER);
        if (ending == 5)
        begin
            flaw = 4'($urandom_range(icw_pkg::EV_RESERVED, icw_pkg::EV_NO_NAME));
            add_member(0, flaw);
        end
        area_end = container_q.size();
        if (ending == 6)
            area_end += $urandom_range(1, 33);
        for (i = 0; i < 8; i++)
            container_q[i] = icw_pkg::sig_byte(3'(i));
        container_q[8] = icw_pkg::STAMP[7:0];
        container_q[9] = icw_pkg::STAMP[15:8];
        for (i = 0; i < 4; i++)
            container_q[10 + i] = area_end[8*i +: 8];
        idx_start = container_q.size();
        if (ending <= 3)
        begin
            for (i = 0; i < 4; i++)
                container_q.push_back(8'h00);
            container_q.push_back(8'(record_starts_q.size()));
            container_q.push_back(8'(record_starts_q.size() >> 8));
            foreach (record_starts_q[rsi])
                for (i = 0; i < 4; i++)
                    container_q.push_back(8'(record_starts_q[rsi] >> (8 * i)));
        end
        for (i = 0; i < container_q.size() + 5; i++)
            end_mark_q.push_back(1'b0);
        if (ending == 2)
        begin
            s = $urandom_range(idx_start, container_q.size() - 1);
            container_q[s] = container_q[s] ^ 8'($urandom_range(1, 255));
        end
        else if (ending == 3)
            end_mark_q[$urandom_range(idx_start, container_q.size() - 1)] = 1'b1;
        else if (ending == 4)
            end_mark_q[$urandom_range(14, area_end - 1)] = 1'b1;
        else if (ending == 7)
            end_mark_q[area_end - 1] = 1'b1;
        // Bytes past the verdict must be ignored.
        for (i = 0; i < 5; i++)
            container_q.push_back(8'($urandom));
        cfg_pos_q = '{record_starts_q[1], record_starts_q[4], record_starts_q[9],
                      record_starts_q[20], record_starts_q[35]};
        cfg_val_q = '{32'hffff_ffff, 32'h0000_0000, $urandom, 32'hffff_ffff, $urandom};
    endtask

    task automatic wait_quiet();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int i;
        int gap;
        int ci;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        build_container();
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= $urandom;
        @(posedge clk);
        cfg_write <= 1'b0;
        ci = 0;
        for (i = 0; i < container_q.size(); i++)
        begin
            gap = ((i / 100) % 4 == 3) ? 0 : $urandom_range(0, 9);
            if (ci < cfg_pos_q.size() && cfg_pos_q[ci] == i)
            begin
                in_valid <= 1'b0;
                wait_quiet();
                cfg_write <= 1'b1;
                cfg_data  <= cfg_val_q[ci];
                @(posedge clk);
                cfg_write <= 1'b0;
                ci++;
            end
            else if (gap > 0)
                in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            in_valid   <= 1'b1;
            byte_value <= container_q[i];
            last_byte  <= end_mark_q[i];
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
        end
        in_valid <= 1'b0;
        wait_quiet();
        repeat (20) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
